@@ hdl/timed_port_debouncer_defines.svh @@
// Assertion macros shared by the timed port debouncer RTL files.
`ifndef TIMED_PORT_DEBOUNCER_DEFINES_SVH
`define TIMED_PORT_DEBOUNCER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge, switched off while reset is asserted.
`define TPD_ASSERT(name, clk_s, rst_s, prop, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Checked on every rising clock edge, also during reset.
`define TPD_ASSERT_NR(name, clk_s, prop, msg) \
	name: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define TPD_ASSERT(name, clk_s, rst_s, prop, msg)

`define TPD_ASSERT_NR(name, clk_s, prop, msg)

`endif

`endif

@@ hdl/tpd_pkg.sv @@
// Shared types, codes and reset constants of the timed port debouncer.
`timescale 1ns / 1ps

package tpd_pkg;

	localparam int DEF_NUM_INPUTS = 8;
	localparam int DEF_TIME_BITS  = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLARITY  = 2'd2;

	// Register values after reset.
	localparam logic [15:0] RST_DEBOUNCE  = 16'd50;
	localparam logic [3:0]  RST_THRESHOLD = 4'd3;
	localparam logic [7:0]  RST_POLARITY  = 8'h18;

	// Failure counter saturates here.
	localparam logic [3:0] FAIL_SAT = 4'd15;
	localparam logic [3:0] FAIL_ONE = 4'h1;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_FAIL   = 2'd1,
		OP_SNAP   = 2'd2,
		OP_RESYNC = 2'd3
	} op_t;

	typedef struct packed {
		logic [15:0] debounce_time_ms;
		logic [3:0]  failure_threshold;
		logic [7:0]  polarity_mask;
	} cfg_t;

	typedef struct packed {
		op_t         opcode;
		logic [7:0]  port_byte;
		logic [31:0] time_ms;
		logic [2:0]  input_index;
	} item_t;

	typedef struct packed {
		logic [7:0]  stable_inputs;
		logic [7:0]  step_changes;
		logic [7:0]  sticky_changes;
		logic [31:0] on_time;
		logic        port_present;
	} result_t;

endpackage

@@ hdl/timed_port_debouncer.sv @@
// Top level of the timed port debouncer: handshakes, configuration and result register.
`timescale 1ns / 1ps
`include "timed_port_debouncer_defines.svh"

// Channel   Handshake             Word
// input     in_valid / in_stall   opcode, port_byte, time_ms, input_index
// output    out_valid / out_stall stable_inputs, step_changes, sticky_changes, on_time,
//                                 port_present
// config    write_en              write_index, write_data
//
// Every word passes through the input register, where the step logic updates the
// debounce state, and then through the result register. A new word is accepted every
// cycle while in_stall is low; the input register holds one word while a result waits,
// so in_stall rises only when both registers are full and out_stall is high.
// Reset clears the debounce state, loads the register defaults and leaves the port
// absent until the first resync word.
module timed_port_debouncer #(
	parameter int NUM_INPUTS = tpd_pkg::DEF_NUM_INPUTS,
	parameter int TIME_BITS  = tpd_pkg::DEF_TIME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       opcode,
	input  logic [7:0]                       port_byte,
	input  logic [31:0]                      time_ms,
	input  logic [2:0]                       input_index,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       stable_inputs,
	output logic [7:0]                       step_changes,
	output logic [7:0]                       sticky_changes,
	output logic [31:0]                      on_time,
	output logic                             port_present,
	input  logic                             write_en,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]    write_index,
	input  logic [tpd_pkg::CFG_DATA_W-1:0]   write_data
);
	import tpd_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    out_valid_q;
	result_t step_res;
	logic    out_free;
	logic    advance;
	logic    in_accept;

	// The result register can take a new word when it is empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time_ms  <= RST_DEBOUNCE;
			cfg_q.failure_threshold <= RST_THRESHOLD;
			cfg_q.polarity_mask     <= RST_POLARITY;
		end else if (write_en) begin
			case (write_index)
				REG_DEBOUNCE:  cfg_q.debounce_time_ms  <= write_data[15:0];
				REG_THRESHOLD: cfg_q.failure_threshold <= write_data[3:0];
				REG_POLARITY:  cfg_q.polarity_mask     <= write_data[7:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.opcode      <= op_t'(opcode);
			item_s1.port_byte   <= port_byte;
			item_s1.time_ms     <= time_ms;
			item_s1.input_index <= input_index;
		end
	end

	// The state advances exactly when the word in the input register moves on.
	tpd_state #(
		.NUM_INPUTS(NUM_INPUTS),
		.TIME_BITS (TIME_BITS)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step_en(advance),
		.item   (item_s1),
		.result (step_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign stable_inputs  = res_q.stable_inputs;
	assign step_changes   = res_q.step_changes;
	assign sticky_changes = res_q.sticky_changes;
	assign on_time        = res_q.on_time;
	assign port_present   = res_q.port_present;

	// A result appears only when a word was waiting in the input register.
	`TPD_ASSERT(a_result_from_s1, clk, arst_n, $rose(out_valid_q) |-> $past(valid_s1), "result appeared without an input word")
	// A word that moves on always lands in the result register.
	`TPD_ASSERT(a_advance_fills_out, clk, arst_n, advance |=> out_valid_q, "advanced word was lost")
	// A word held back in the input register keeps its contents.
	`TPD_ASSERT(a_s1_holds, clk, arst_n, valid_s1 && !out_free |=> valid_s1 && $stable(item_s1), "held input word changed")

endmodule

@@ hdl/tpd_state.sv @@
// Debounce state registers and the combinational step logic that updates them.
`timescale 1ns / 1ps
`include "timed_port_debouncer_defines.svh"

module tpd_state #(
	parameter int NUM_INPUTS = tpd_pkg::DEF_NUM_INPUTS,
	parameter int TIME_BITS  = tpd_pkg::DEF_TIME_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tpd_pkg::cfg_t     cfg,
	input  logic              step_en,
	input  tpd_pkg::item_t    item,
	output tpd_pkg::result_t  result
);
	import tpd_pkg::*;

	logic [NUM_INPUTS-1:0] last_raw_q, last_raw_d;
	logic [NUM_INPUTS-1:0] stable_q, stable_d;
	logic [NUM_INPUTS-1:0] sticky_q, sticky_d;
	logic [TIME_BITS-1:0]  change_time_q, change_time_d;
	logic [TIME_BITS-1:0]  rise_q [NUM_INPUTS];
	logic [TIME_BITS-1:0]  rise_d [NUM_INPUTS];
	logic [3:0]            fail_q, fail_d;
	logic                  present_q, present_d;

	logic [NUM_INPUTS-1:0] corr;
	logic [NUM_INPUTS-1:0] changed;
	logic [NUM_INPUTS-1:0] sticky_out;
	logic [TIME_BITS-1:0]  now;
	logic [TIME_BITS-1:0]  elapsed;
	logic [3:0]            fail_inc;
	logic [TIME_BITS-1:0]  on_sel;

	assign corr     = NUM_INPUTS'(item.port_byte ^ cfg.polarity_mask);
	assign now      = TIME_BITS'(item.time_ms);
	assign elapsed  = now - change_time_q;
	assign fail_inc = (fail_q < FAIL_SAT) ? (fail_q + FAIL_ONE) : fail_q;

	always_comb begin
		last_raw_d    = last_raw_q;
		stable_d      = stable_q;
		sticky_d      = sticky_q;
		change_time_d = change_time_q;
		fail_d        = fail_q;
		present_d     = present_q;
		changed       = '0;
		sticky_out    = sticky_q;
		case (item.opcode)
			OP_SAMPLE: begin
				if (present_q) begin
					fail_d = '0;
					if (corr != last_raw_q) begin
						last_raw_d    = corr;
						change_time_d = now;
					end else if (elapsed >= TIME_BITS'(cfg.debounce_time_ms)) begin
						changed  = stable_q ^ corr;
						stable_d = corr;
						sticky_d = sticky_q | changed;
					end
				end
				sticky_out = sticky_d;
			end
			OP_FAIL: begin
				if (present_q) begin
					fail_d = fail_inc;
					if (fail_inc >= cfg.failure_threshold) begin
						present_d = 1'b0;
					end
				end
			end
			OP_SNAP: begin
				sticky_d = '0;
			end
			OP_RESYNC: begin
				last_raw_d    = corr;
				stable_d      = corr;
				change_time_d = now;
				sticky_d      = '0;
				fail_d        = '0;
				present_d     = 1'b1;
				sticky_out    = '0;
			end
			default: begin
				sticky_out = sticky_q;
			end
		endcase
	end

	// Rise times: each lane takes the timestamp when its stable bit goes high.
	always_comb begin
		on_sel = '0;
		for (int i = 0; i < NUM_INPUTS; i++) begin
			rise_d[i] = (changed[i] && corr[i]) ? now : rise_q[i];
			if (item.input_index == 3'(i)) begin
				on_sel = rise_d[i];
			end
		end
	end

	always_comb begin
		result.stable_inputs  = 8'(stable_d);
		result.step_changes   = 8'(changed);
		result.sticky_changes = 8'(sticky_out);
		result.on_time        = 32'(on_sel);
		result.port_present   = present_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= '0;
			stable_q      <= '0;
			sticky_q      <= '0;
			change_time_q <= '0;
			fail_q        <= '0;
			present_q     <= 1'b0;
			for (int i = 0; i < NUM_INPUTS; i++) begin
				rise_q[i] <= '0;
			end
		end else if (step_en) begin
			last_raw_q    <= last_raw_d;
			stable_q      <= stable_d;
			sticky_q      <= sticky_d;
			change_time_q <= change_time_d;
			fail_q        <= fail_d;
			present_q     <= present_d;
			for (int i = 0; i < NUM_INPUTS; i++) begin
				rise_q[i] <= rise_d[i];
			end
		end
	end

	// The port can only be lost through a read failure.
	`TPD_ASSERT(a_absent_only_by_fail, clk, arst_n, $fell(present_q) |-> $past(step_en && item.opcode == OP_FAIL), "port went absent without a read failure")
	// A resync leaves the port present with clean counters.
	`TPD_ASSERT(a_resync_clears, clk, arst_n, step_en && item.opcode == OP_RESYNC |=> present_q && fail_q == '0 && sticky_q == '0, "resync did not restore the port state")
	// Reported changes must show up in the stable byte.
	`TPD_ASSERT(a_change_moves_stable, clk, arst_n, step_en && result.step_changes != 8'd0 |=> stable_q != $past(stable_q), "reported change without a stable byte update")

endmodule
